// ----- hdl/bma_pkg.sv -----
`default_nettype none
package bma_pkg;

    localparam int MAX_ORDER    = 10;
    localparam int HANDLE_WIDTH = 16;

    localparam int ORD_W     = $clog2(MAX_ORDER + 1);
    localparam int STK_DEPTH = 2 << MAX_ORDER;
    localparam int STK_AW    = MAX_ORDER + 1;
    localparam int TBL_DEPTH = 1 << MAX_ORDER;
    localparam int TBL_AW    = MAX_ORDER;
    localparam int CNT_W     = MAX_ORDER + 1;

    localparam int TOTAL_W   = 23;
    localparam int REQ_W     = 22;
    localparam int OADDR_W   = 22;
    localparam int MBL_W     = 4;
    localparam int MAX_MBL   = (1 << MBL_W) - 1;
    localparam int MINB_W    = MAX_MBL + 1;
    localparam int ADDR_W    = MAX_MBL + MAX_ORDER;
    localparam int SIZE_W    = ADDR_W + 1;
    localparam int LP_W      = $clog2(REQ_W + 1);

    localparam logic [TOTAL_W-1:0] RESET_TOTAL = TOTAL_W'(1024);
    localparam logic [MBL_W-1:0]   RESET_MBL   = '0;

    typedef enum logic [2:0] {
        ST_ALLOC     = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_NO_BLOCK  = 3'd2,
        ST_FREED     = 3'd3,
        ST_UNKNOWN   = 3'd4
    } status_t;

    typedef enum logic {
        CFG_TOTAL = 1'b0,
        CFG_MINB  = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        PH_CLEAR, PH_SEED, PH_IDLE, PH_ROUND, PH_CHECK, PH_TSCAN,
        PH_FIND, PH_POP, PH_POPW, PH_SPLIT, PH_COMMIT, PH_FREL,
        PH_MCHK, PH_MSCAN, PH_SHIFT, PH_MERGE, PH_PUSH, PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   accept;
        logic   load_out;
    } bma_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic round_ok;
        logic too_large;
        logic tbl_hit;
        logic tbl_miss;
        logic cur_over;
        logic cnt_nz;
        logic cur_gt_need;
        logic merge_stop;
        logic stk_hit;
        logic stk_miss;
        logic hit_last;
        logic shift_done;
        logic is_free;
    } bma_sts_t;

    typedef struct packed {
        logic                    valid;
        logic [HANDLE_WIDTH-1:0] tag;
        logic [ADDR_W-1:0]       addr;
        logic [ORD_W-1:0]        order;
    } tbl_entry_t;

    // stacks sit back to back, largest (order 0) first
    function automatic logic [STK_AW-1:0] stack_base(input logic [ORD_W-1:0] k);
        int b;
        b = (2 << MAX_ORDER) - (2 << (MAX_ORDER - int'(k)));
        return STK_AW'(b);
    endfunction

    function automatic logic [CNT_W-1:0] stack_cap(input logic [ORD_W-1:0] k);
        int c;
        c = 1 << (MAX_ORDER - int'(k));
        return CNT_W'(c);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/bma_ram.sv -----
`default_nettype none
module bma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hdl/bma_ctrl.sv -----
`default_nettype none
module bma_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              in_valid,
    input  wire logic              mode,
    input  wire logic              out_stall,
    input  wire bma_pkg::bma_sts_t sts,
    output bma_pkg::bma_cmd_t      cmd,
    output logic                   in_stall,
    output logic                   out_valid
);
    import bma_pkg::*;

    phase_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = (state_reg == PH_DONE) && !(out_valid_reg && out_stall);
        unique case (state_reg)
            PH_CLEAR:  if (sts.clr_done) state_next = PH_SEED;
            PH_SEED:   state_next = PH_IDLE;
            PH_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mode ? PH_TSCAN : PH_ROUND;
                end
            end
            PH_ROUND:  if (sts.round_ok) state_next = PH_CHECK;
            PH_CHECK:  state_next = sts.too_large ? PH_DONE : PH_TSCAN;
            PH_TSCAN:
            begin
                if (sts.tbl_hit)
                begin
                    state_next = sts.is_free ? PH_FREL : PH_FIND;
                end
                else if (sts.tbl_miss)
                begin
                    state_next = PH_DONE;
                end
            end
            PH_FIND:
            begin
                if (sts.cur_over)
                begin
                    state_next = PH_DONE;
                end
                else if (sts.cnt_nz)
                begin
                    state_next = PH_POP;
                end
            end
            PH_POP:    state_next = PH_POPW;
            PH_POPW:   state_next = PH_SPLIT;
            PH_SPLIT:  if (!sts.cur_gt_need) state_next = PH_COMMIT;
            PH_COMMIT: state_next = PH_DONE;
            PH_FREL:   state_next = PH_MCHK;
            PH_MCHK:   state_next = sts.merge_stop ? PH_PUSH : PH_MSCAN;
            PH_MSCAN:
            begin
                if (sts.stk_hit)
                begin
                    state_next = sts.hit_last ? PH_MERGE : PH_SHIFT;
                end
                else if (sts.stk_miss)
                begin
                    state_next = PH_PUSH;
                end
            end
            PH_SHIFT:  if (sts.shift_done) state_next = PH_MERGE;
            PH_MERGE:  state_next = PH_MCHK;
            PH_PUSH:   state_next = PH_DONE;
            PH_DONE:   if (load_out) state_next = PH_IDLE;
            default:   state_next = PH_CLEAR;
        endcase
        // a register write restarts the allocator from scratch
        if (cfg_we)
        begin
            state_next = PH_CLEAR;
        end
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    assign cmd.phase    = state_reg;
    assign cmd.accept   = (state_reg == PH_IDLE) && in_valid;
    assign cmd.load_out = load_out;
    assign in_stall     = (state_reg != PH_IDLE);
    assign out_valid    = out_valid_reg;

endmodule
`default_nettype wire

// ----- hdl/bma_dp.sv -----
`default_nettype none
module bma_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [bma_pkg::TOTAL_W-1:0]      cfg_wdata,
    input  wire bma_pkg::bma_cmd_t                cmd,
    input  wire logic                             mode,
    input  wire logic [bma_pkg::REQ_W-1:0]        req_size,
    input  wire logic [bma_pkg::HANDLE_WIDTH-1:0] handle_in,
    output bma_pkg::bma_sts_t                     sts,
    output logic [2:0]                            status,
    output logic [bma_pkg::OADDR_W-1:0]           block_addr,
    output logic [bma_pkg::TOTAL_W-1:0]           block_size,
    output logic [bma_pkg::HANDLE_WIDTH-1:0]      handle_out
);
    import bma_pkg::*;

    // control state
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic [MBL_W-1:0]        mbl_reg, mbl_next;
    logic [TBL_AW-1:0]       clr_idx_reg, clr_idx_next;
    logic [ORD_W-1:0]        top_reg, top_next;
    logic [CNT_W-1:0]        counts_reg [MAX_ORDER+1];
    logic [CNT_W-1:0]        counts_next [MAX_ORDER+1];
    logic [HANDLE_WIDTH-1:0] nh_reg, nh_next;
    logic                    rd_vld_reg, rd_vld_next;

    // working payload
    logic                    mode_reg, mode_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    logic [HANDLE_WIDTH-1:0] hin_reg, hin_next;
    logic [LP_W-1:0]         lp_reg, lp_next;
    logic [TOTAL_W-1:0]      p_reg, p_next;
    logic [LP_W-1:0]         need_reg, need_next;
    logic [LP_W-1:0]         cur_reg, cur_next;
    logic [STK_AW-1:0]       scan_idx_reg, scan_idx_next;
    logic [STK_AW-1:0]       rd_idx_reg, rd_idx_next;
    logic [TBL_AW-1:0]       slot_reg, slot_next;
    logic [ADDR_W-1:0]       start_reg, start_next;
    logic [ORD_W-1:0]        k_reg, k_next;
    logic [SIZE_W-1:0]       size_reg, size_next;
    status_t                 res_st_reg, res_st_next;
    logic [OADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic [TOTAL_W-1:0]      res_size_reg, res_size_next;
    logic [HANDLE_WIDTH-1:0] res_hdl_reg, res_hdl_next;
    status_t                 status_reg, status_next;
    logic [OADDR_W-1:0]      oaddr_reg, oaddr_next;
    logic [TOTAL_W-1:0]      osize_reg, osize_next;
    logic [HANDLE_WIDTH-1:0] ohdl_reg, ohdl_next;

    // memories
    logic                    tbl_we;
    logic [TBL_AW-1:0]       tbl_waddr, tbl_raddr;
    tbl_entry_t              tbl_wdata, tbl_rd;
    logic                    stk_we;
    logic [STK_AW-1:0]       stk_waddr, stk_raddr;
    logic [ADDR_W-1:0]       stk_wdata, stk_rd;

    // helpers
    logic [MINB_W-1:0]       minb;
    logic [TOTAL_W-1:0]      pow_lp, p_calc;
    logic [LP_W-1:0]         need_calc;
    logic [ORD_W-1:0]        cnt_idx;
    logic [CNT_W-1:0]        cnt_sel, cap_sel;
    logic [STK_AW-1:0]       base_sel, last_idx;
    logic                    room;
    logic [ADDR_W-1:0]       buddy, split_addr;
    logic                    tbl_match, stk_match;
    logic [HANDLE_WIDTH-1:0] nh_inc;

    bma_ram #(.WIDTH($bits(tbl_entry_t)), .DEPTH(TBL_DEPTH)) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rd)
    );

    bma_ram #(.WIDTH(ADDR_W), .DEPTH(STK_DEPTH)) u_stk (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rd)
    );

    assign minb      = MINB_W'(1) << mbl_reg;
    assign pow_lp    = TOTAL_W'(1) << lp_reg;
    assign p_calc    = (pow_lp < TOTAL_W'(minb)) ? TOTAL_W'(minb) : pow_lp;
    assign need_calc = (pow_lp < TOTAL_W'(minb)) ? '0 : lp_reg - LP_W'(mbl_reg);

    // one order is looked at per cycle; the phase picks which
    always_comb
    begin
        unique case (cmd.phase)
            PH_SPLIT:        cnt_idx = ORD_W'(cur_reg - LP_W'(1));
            PH_FIND, PH_POP: cnt_idx = ORD_W'(cur_reg);
            PH_SEED:         cnt_idx = top_reg;
            default:         cnt_idx = k_reg;
        endcase
    end

    assign cnt_sel    = (int'(cnt_idx) <= MAX_ORDER) ? counts_reg[cnt_idx] : '0;
    assign cap_sel    = stack_cap(cnt_idx);
    assign base_sel   = stack_base(cnt_idx);
    assign room       = cnt_sel < cap_sel;
    assign last_idx   = STK_AW'(cnt_sel - CNT_W'(1));
    assign buddy      = start_reg ^ ADDR_W'(size_reg);
    assign split_addr = start_reg + (ADDR_W'(minb) << cnt_idx);
    assign tbl_match  = mode_reg ? (tbl_rd.valid && tbl_rd.tag == hin_reg) : !tbl_rd.valid;
    assign stk_match  = (stk_rd == buddy);
    assign nh_inc     = nh_reg + HANDLE_WIDTH'(1);
    assign tbl_raddr  = scan_idx_reg[TBL_AW-1:0];

    assign sts.clr_done    = (clr_idx_reg == TBL_AW'(TBL_DEPTH - 1));
    assign sts.round_ok    = (pow_lp >= TOTAL_W'(req_reg));
    assign sts.too_large   = (p_calc > total_reg);
    assign sts.tbl_hit     = rd_vld_reg && tbl_match;
    assign sts.tbl_miss    = rd_vld_reg && !tbl_match
                             && (rd_idx_reg == STK_AW'(TBL_DEPTH - 1));
    assign sts.cur_over    = (cur_reg > LP_W'(top_reg));
    assign sts.cnt_nz      = (cnt_sel != '0);
    assign sts.cur_gt_need = (cur_reg > need_reg);
    assign sts.merge_stop  = (k_reg >= top_reg) || (cnt_sel == '0);
    assign sts.stk_hit     = rd_vld_reg && stk_match;
    assign sts.stk_miss    = rd_vld_reg && !stk_match && (rd_idx_reg == last_idx);
    assign sts.hit_last    = (rd_idx_reg == last_idx);
    assign sts.shift_done  = rd_vld_reg && (rd_idx_reg == last_idx);
    assign sts.is_free     = mode_reg;

    always_comb
    begin
        total_next    = total_reg;
        mbl_next      = mbl_reg;
        clr_idx_next  = clr_idx_reg;
        top_next      = top_reg;
        counts_next   = counts_reg;
        nh_next       = nh_reg;
        rd_vld_next   = rd_vld_reg;
        mode_next     = mode_reg;
        req_next      = req_reg;
        hin_next      = hin_reg;
        lp_next       = lp_reg;
        p_next        = p_reg;
        need_next     = need_reg;
        cur_next      = cur_reg;
        scan_idx_next = scan_idx_reg;
        rd_idx_next   = rd_idx_reg;
        slot_next     = slot_reg;
        start_next    = start_reg;
        k_next        = k_reg;
        size_next     = size_reg;
        res_st_next   = res_st_reg;
        res_addr_next = res_addr_reg;
        res_size_next = res_size_reg;
        res_hdl_next  = res_hdl_reg;
        status_next   = status_reg;
        oaddr_next    = oaddr_reg;
        osize_next    = osize_reg;
        ohdl_next     = ohdl_reg;
        tbl_we        = 1'b0;
        tbl_waddr     = slot_reg;
        tbl_wdata     = '0;
        stk_we        = 1'b0;
        stk_waddr     = base_sel + STK_AW'(cnt_sel);
        stk_wdata     = start_reg;
        stk_raddr     = base_sel + scan_idx_reg;

        unique case (cmd.phase)
            PH_CLEAR:
            begin
                tbl_we       = 1'b1;
                tbl_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + TBL_AW'(1);
                // top order: smallest k whose block covers the total
                if ((int'(top_reg) < MAX_ORDER)
                    && ((SIZE_W'(minb) << top_reg) < SIZE_W'(total_reg)))
                begin
                    top_next = top_reg + ORD_W'(1);
                end
            end
            PH_SEED:
            begin
                for (int i = 0; i <= MAX_ORDER; i++)
                begin
                    counts_next[i] = '0;
                end
                counts_next[top_reg] = CNT_W'(1);
                stk_we    = 1'b1;
                stk_waddr = base_sel;
                stk_wdata = '0;
                nh_next   = HANDLE_WIDTH'(1);
            end
            PH_IDLE:
            begin
                if (cmd.accept)
                begin
                    mode_next     = mode;
                    req_next      = req_size;
                    hin_next      = handle_in;
                    lp_next       = '0;
                    res_st_next   = ST_ALLOC;
                    res_addr_next = '0;
                    res_size_next = '0;
                    res_hdl_next  = '0;
                    scan_idx_next = '0;
                    rd_vld_next   = 1'b0;
                end
            end
            PH_ROUND:
            begin
                if (!sts.round_ok)
                begin
                    lp_next = lp_reg + LP_W'(1);
                end
            end
            PH_CHECK:
            begin
                p_next        = p_calc;
                need_next     = need_calc;
                cur_next      = need_calc;
                scan_idx_next = '0;
                rd_vld_next   = 1'b0;
                if (sts.too_large)
                begin
                    res_st_next = ST_TOO_LARGE;
                end
            end
            PH_TSCAN:
            begin
                scan_idx_next = scan_idx_reg + STK_AW'(1);
                rd_vld_next   = 1'b1;
                rd_idx_next   = scan_idx_reg;
                if (sts.tbl_hit)
                begin
                    slot_next  = rd_idx_reg[TBL_AW-1:0];
                    start_next = tbl_rd.addr;
                    k_next     = tbl_rd.order;
                end
                else if (sts.tbl_miss)
                begin
                    res_st_next = mode_reg ? ST_UNKNOWN : ST_NO_BLOCK;
                end
            end
            PH_FIND:
            begin
                if (sts.cur_over)
                begin
                    res_st_next = ST_NO_BLOCK;
                end
                else if (!sts.cnt_nz)
                begin
                    cur_next = cur_reg + LP_W'(1);
                end
            end
            PH_POP:
            begin
                counts_next[cnt_idx] = cnt_sel - CNT_W'(1);
                stk_raddr            = base_sel + last_idx;
            end
            PH_POPW:
            begin
                start_next = stk_rd;
            end
            PH_SPLIT:
            begin
                if (sts.cur_gt_need)
                begin
                    cur_next = cur_reg - LP_W'(1);
                    if (room)
                    begin
                        stk_we               = 1'b1;
                        stk_wdata            = split_addr;
                        counts_next[cnt_idx] = cnt_sel + CNT_W'(1);
                    end
                end
            end
            PH_COMMIT:
            begin
                tbl_we          = 1'b1;
                tbl_wdata.valid = 1'b1;
                tbl_wdata.tag   = nh_reg;
                tbl_wdata.addr  = start_reg;
                tbl_wdata.order = ORD_W'(need_reg);
                res_st_next     = ST_ALLOC;
                res_addr_next   = start_reg[OADDR_W-1:0];
                res_size_next   = p_reg;
                res_hdl_next    = nh_reg;
                nh_next         = (nh_inc == '0) ? HANDLE_WIDTH'(1) : nh_inc;
            end
            PH_FREL:
            begin
                tbl_we    = 1'b1;
                size_next = SIZE_W'(minb) << k_reg;
            end
            PH_MCHK:
            begin
                scan_idx_next = '0;
                rd_vld_next   = 1'b0;
            end
            PH_MSCAN:
            begin
                scan_idx_next = scan_idx_reg + STK_AW'(1);
                rd_vld_next   = 1'b1;
                rd_idx_next   = scan_idx_reg;
                if (sts.stk_hit)
                begin
                    // close the gap: move every later entry down one
                    scan_idx_next = rd_idx_reg + STK_AW'(1);
                    rd_vld_next   = 1'b0;
                end
            end
            PH_SHIFT:
            begin
                scan_idx_next = scan_idx_reg + STK_AW'(1);
                rd_vld_next   = 1'b1;
                rd_idx_next   = scan_idx_reg;
                if (rd_vld_reg)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = base_sel + rd_idx_reg - STK_AW'(1);
                    stk_wdata = stk_rd;
                end
            end
            PH_MERGE:
            begin
                counts_next[cnt_idx] = cnt_sel - CNT_W'(1);
                if (buddy < start_reg)
                begin
                    start_next = buddy;
                end
                size_next = size_reg << 1;
                k_next    = k_reg + ORD_W'(1);
            end
            PH_PUSH:
            begin
                if (room)
                begin
                    stk_we               = 1'b1;
                    counts_next[cnt_idx] = cnt_sel + CNT_W'(1);
                end
                res_st_next   = ST_FREED;
                res_addr_next = start_reg[OADDR_W-1:0];
                res_size_next = size_reg[TOTAL_W-1:0];
                res_hdl_next  = '0;
            end
            PH_DONE:
            begin
                if (cmd.load_out)
                begin
                    status_next = res_st_reg;
                    oaddr_next  = res_addr_reg;
                    osize_next  = res_size_reg;
                    ohdl_next   = res_hdl_reg;
                end
            end
            default:
            begin
                rd_vld_next = 1'b0;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TOTAL: total_next = cfg_wdata;
                CFG_MINB:  mbl_next   = cfg_wdata[MBL_W-1:0];
            endcase
            clr_idx_next = '0;
            top_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= RESET_TOTAL;
            mbl_reg     <= RESET_MBL;
            clr_idx_reg <= '0;
            top_reg     <= '0;
            for (int i = 0; i <= MAX_ORDER; i++)
            begin
                counts_reg[i] <= '0;
            end
            nh_reg      <= HANDLE_WIDTH'(1);
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            total_reg   <= total_next;
            mbl_reg     <= mbl_next;
            clr_idx_reg <= clr_idx_next;
            top_reg     <= top_next;
            counts_reg  <= counts_next;
            nh_reg      <= nh_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        req_reg      <= req_next;
        hin_reg      <= hin_next;
        lp_reg       <= lp_next;
        p_reg        <= p_next;
        need_reg     <= need_next;
        cur_reg      <= cur_next;
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= rd_idx_next;
        slot_reg     <= slot_next;
        start_reg    <= start_next;
        k_reg        <= k_next;
        size_reg     <= size_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        res_size_reg <= res_size_next;
        res_hdl_reg  <= res_hdl_next;
        status_reg   <= status_next;
        oaddr_reg    <= oaddr_next;
        osize_reg    <= osize_next;
        ohdl_reg     <= ohdl_next;
    end

    assign status     = status_reg;
    assign block_addr = oaddr_reg;
    assign block_size = osize_reg;
    assign handle_out = ohdl_reg;

endmodule
`default_nettype wire

// ----- hdl/buddy_memory_allocator.sv -----
`default_nettype none
// Buddy allocator over a power-of-two span, one LIFO free stack per order,
// handles kept in a 1024-entry table. One request is worked on at a time and
// the block takes the next beat as soon as the result sits in the output
// register. An allocate rounds the request up to a power of two, scans the
// table for the lowest free slot, searches upward from the needed order for
// a non-empty stack, pops a block from it and splits down to the needed order.
// A free scans the table to the handle's slot, then for each merge level
// scans that order's stack up to the buddy and shifts the entries behind
// it, both one entry a cycle through the stack memory's single read port.
// After reset and after every register write a clearing pass sweeps the
// handle table; no beat is taken until it is done.
module buddy_memory_allocator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [bma_pkg::TOTAL_W-1:0]      cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             mode,
    input  wire logic [bma_pkg::REQ_W-1:0]        req_size,
    input  wire logic [bma_pkg::HANDLE_WIDTH-1:0] handle_in,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [2:0]                            status,
    output logic [bma_pkg::OADDR_W-1:0]           block_addr,
    output logic [bma_pkg::TOTAL_W-1:0]           block_size,
    output logic [bma_pkg::HANDLE_WIDTH-1:0]      handle_out
);
    import bma_pkg::*;

    bma_cmd_t cmd;
    bma_sts_t sts;

    bma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .in_valid  (in_valid),
        .mode      (mode),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    bma_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .mode       (mode),
        .req_size   (req_size),
        .handle_in  (handle_in),
        .sts        (sts),
        .status     (status),
        .block_addr (block_addr),
        .block_size (block_size),
        .handle_out (handle_out)
    );

    // a granted block is always a power of two
    a_alloc_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_ALLOC) |-> $onehot(block_size))
        else $error("granted size not a power of two");

    // handles are only issued on a grant, and never zero
    a_alloc_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_ALLOC) |-> (handle_out != '0))
        else $error("grant without a handle");

    a_other_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_ALLOC) |-> (handle_out == '0))
        else $error("handle on a non-grant result");

    // one beat in flight: after an accept the input side closes
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after an accept");

endmodule
`default_nettype wire
